// ===== src/mcp_pkg.sv =====
// shared constants, types and the brightness table for the chromatic mandelbrot core
// no dependencies
package mcp_pkg;

  localparam int MAX_ITER   = 128;
  localparam int COORD_BITS = 10;
  localparam int CNT_W      = 8;
  localparam int ITER_W     = $clog2(MAX_ITER + 1);
  localparam int IDX_W      = $clog2(MAX_ITER);
  localparam int DATA_W     = 32;
  localparam int STEP_W     = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int COLOR_W    = 16;

  localparam logic [DATA_W-1:0] FOUR_Q28 = 32'h4000_0000;

  localparam logic [DATA_W-1:0] MIN_REAL_RST = 32'hD800_0000;
  localparam logic [DATA_W-1:0] MIN_IMAG_RST = 32'hEC00_0000;
  localparam logic [STEP_W-1:0] REAL_STEP_RST = 31'd2936013;
  localparam logic [STEP_W-1:0] IMAG_STEP_RST = 31'd2796203;
  localparam logic [STEP_W-1:0] CH_OFFSET_RST = 31'd968884;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_REAL  = 3'd0,
    REG_MIN_IMAG  = 3'd1,
    REG_REAL_STEP = 3'd2,
    REG_IMAG_STEP = 3'd3,
    REG_CH_OFFSET = 3'd4
  } cfg_reg_e;

  typedef logic [7:0] bright_lut_t [MAX_ITER];

  // largest k with k*k*max <= n*255*255
  function automatic bright_lut_t build_bright_lut();
    bright_lut_t lut;
    int          k;
    for (int n = 0; n < MAX_ITER; n++) begin
      k = 0;
      for (int j = 1; j < 256; j++) begin
        if (j * j * MAX_ITER <= n * 65025) begin
          k = j;
        end
      end
      lut[n] = 8'(k);
    end
    return lut;
  endfunction

  localparam bright_lut_t BRIGHT_LUT = build_bright_lut();

endpackage

// ===== src/mcp_pix_if.sv =====
// pixel coordinate channel, valid/ready handshake
// depends on mcp_pkg
interface mcp_pix_if;
  logic                             valid;
  logic                             ready;
  logic [mcp_pkg::COORD_BITS-1:0]   pixel_x;
  logic [mcp_pkg::COORD_BITS-1:0]   pixel_y;

  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

// ===== src/mcp_res_if.sv =====
// colour result channel, valid/ready handshake
// depends on mcp_pkg
interface mcp_res_if;
  logic                          valid;
  logic                          ready;
  logic [mcp_pkg::COLOR_W-1:0]   pixel_color;
  logic [mcp_pkg::CNT_W-1:0]     red_count;
  logic [mcp_pkg::CNT_W-1:0]     green_count;
  logic [mcp_pkg::CNT_W-1:0]     blue_count;

  modport source (output valid, pixel_color, red_count, green_count, blue_count, input ready);
  modport sink   (input valid, pixel_color, red_count, green_count, blue_count, output ready);
endinterface

// ===== src/mandelbrot_chromatic_pixel_core.sv =====
// top level: config registers, sequencer, escape-time datapath and output register
// depends on mcp_pkg, mcp_pix_if, mcp_res_if, mcp_mul, mcp_colour
//
// One pixel word in, one colour word out. All products go through a single 32x32
// multiplier with a registered output, so an escape iteration steps through zr^2,
// zi^2, zr*zi, then compare and update. A pixel passes the set-up states S_XMUL,
// S_YMUL and S_CI, then for each of the three channels the channel set-up state S_CH
// and its escape iterations, then S_DONE, which loads the output register.
// pix_i.ready is high only between pixels; a finished result waits in the output
// register while the next pixel is taken.
module mandelbrot_chromatic_pixel_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  mcp_pix_if.sink                            pix_i,
  mcp_res_if.source                          res_o,
  input  logic                               cfg_we_i,
  input  logic [mcp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mcp_pkg::DATA_W-1:0]         cfg_data_i
);

  localparam int DW = mcp_pkg::DATA_W;
  localparam int IW = mcp_pkg::ITER_W;

  typedef enum logic [3:0] {
    S_IDLE, S_XMUL, S_YMUL, S_CI, S_CH, S_RR, S_II, S_RI, S_UPD, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } ch_e;

  state_e state_q;
  ch_e    ch_q;

  logic [DW-1:0]                  min_real_q, min_imag_q;
  logic [mcp_pkg::STEP_W-1:0]     real_step_q, imag_step_q, ch_off_q;

  logic [mcp_pkg::COORD_BITS-1:0] x_q, y_q;
  logic [DW-1:0]                  cr_base_q, ci_q, cr_q;
  logic [DW-1:0]                  zr_q, zi_q, zr2_q, zi2_q;
  logic [IW-1:0]                  n_q;
  logic [IW-1:0]                  red_n_q, green_n_q, blue_n_q;

  logic                           out_valid_q;
  logic [mcp_pkg::COLOR_W-1:0]    color_q;
  logic [mcp_pkg::CNT_W-1:0]      red_cnt_q, green_cnt_q, blue_cnt_q;

  logic signed [DW-1:0]           mul_a, mul_b;
  logic signed [2*DW-1:0]         prod;
  logic                           mul_en;
  logic [DW-1:0]                  prod_q28, prod_q27, prod_lo;
  logic [DW-1:0]                  mag_sum, ch_off_ext;
  logic                           escaped, at_limit;
  logic [IW-1:0]                  fin_n;
  logic [mcp_pkg::COLOR_W-1:0]    color;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_real_q  <= mcp_pkg::MIN_REAL_RST;
      min_imag_q  <= mcp_pkg::MIN_IMAG_RST;
      real_step_q <= mcp_pkg::REAL_STEP_RST;
      imag_step_q <= mcp_pkg::IMAG_STEP_RST;
      ch_off_q    <= mcp_pkg::CH_OFFSET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcp_pkg::REG_MIN_REAL:  min_real_q  <= cfg_data_i;
        mcp_pkg::REG_MIN_IMAG:  min_imag_q  <= cfg_data_i;
        mcp_pkg::REG_REAL_STEP: real_step_q <= cfg_data_i[mcp_pkg::STEP_W-1:0];
        mcp_pkg::REG_IMAG_STEP: imag_step_q <= cfg_data_i[mcp_pkg::STEP_W-1:0];
        mcp_pkg::REG_CH_OFFSET: ch_off_q    <= cfg_data_i[mcp_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    unique case (state_q)
      S_XMUL: begin
        mul_a  = signed'(DW'(x_q));
        mul_b  = signed'(DW'(real_step_q));
        mul_en = 1'b1;
      end
      S_YMUL: begin
        mul_a  = signed'(DW'(y_q));
        mul_b  = signed'(DW'(imag_step_q));
        mul_en = 1'b1;
      end
      S_RR: begin
        mul_a  = signed'(zr_q);
        mul_b  = signed'(zr_q);
        mul_en = 1'b1;
      end
      S_II: begin
        mul_a  = signed'(zi_q);
        mul_b  = signed'(zi_q);
        mul_en = 1'b1;
      end
      S_RI: begin
        mul_a  = signed'(zr_q);
        mul_b  = signed'(zi_q);
        mul_en = 1'b1;
      end
      default: ;
    endcase
  end

  mcp_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign prod_q28   = prod[DW+27:28];
  assign prod_q27   = prod[DW+26:27];
  assign prod_lo    = prod[DW-1:0];
  assign ch_off_ext = DW'(ch_off_q);
  assign mag_sum    = zr2_q + zi2_q;
  assign escaped    = signed'(mag_sum) > signed'(mcp_pkg::FOUR_Q28);
  assign at_limit   = (n_q == IW'(mcp_pkg::MAX_ITER - 1));
  assign fin_n      = escaped ? n_q : n_q + IW'(1);

  mcp_colour u_colour (
    .red_n_i   (red_n_q),
    .green_n_i (green_n_q),
    .blue_n_i  (blue_n_q),
    .color_o   (color)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= CH_RED;
      out_valid_q <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      cr_base_q   <= '0;
      ci_q        <= '0;
      cr_q        <= '0;
      zr_q        <= '0;
      zi_q        <= '0;
      zr2_q       <= '0;
      zi2_q       <= '0;
      n_q         <= '0;
      red_n_q     <= '0;
      green_n_q   <= '0;
      blue_n_q    <= '0;
      color_q     <= '0;
      red_cnt_q   <= '0;
      green_cnt_q <= '0;
      blue_cnt_q  <= '0;
    end else begin
      if (state_q == S_DONE && (!out_valid_q || res_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pix_i.valid) begin
            x_q     <= pix_i.pixel_x;
            y_q     <= pix_i.pixel_y;
            state_q <= S_XMUL;
          end
        end
        S_XMUL: begin
          state_q <= S_YMUL;
        end
        S_YMUL: begin
          cr_base_q <= min_real_q + prod_lo;
          ch_q      <= CH_RED;
          state_q   <= S_CI;
        end
        S_CI: begin
          ci_q    <= min_imag_q + prod_lo;
          state_q <= S_CH;
        end
        S_CH: begin
          zr_q <= '0;
          zi_q <= '0;
          n_q  <= '0;
          unique case (ch_q)
            CH_RED:   cr_q <= cr_base_q - ch_off_ext;
            CH_GREEN: cr_q <= cr_base_q;
            CH_BLUE:  cr_q <= cr_base_q + ch_off_ext;
            default: ;
          endcase
          state_q <= S_RR;
        end
        S_RR: begin
          state_q <= S_II;
        end
        S_II: begin
          zr2_q   <= prod_q28;
          state_q <= S_RI;
        end
        S_RI: begin
          zi2_q   <= prod_q28;
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (escaped || at_limit) begin
            unique case (ch_q)
              CH_RED:   red_n_q   <= fin_n;
              CH_GREEN: green_n_q <= fin_n;
              CH_BLUE:  blue_n_q  <= fin_n;
              default: ;
            endcase
            if (ch_q == CH_BLUE) begin
              state_q <= S_DONE;
            end else begin
              ch_q    <= (ch_q == CH_RED) ? CH_GREEN : CH_BLUE;
              state_q <= S_CH;
            end
          end else begin
            zi_q    <= prod_q27 + ci_q;
            zr_q    <= zr2_q - zi2_q + cr_q;
            n_q     <= n_q + IW'(1);
            state_q <= S_RR;
          end
        end
        S_DONE: begin
          if (!out_valid_q || res_o.ready) begin
            color_q     <= color;
            red_cnt_q   <= mcp_pkg::CNT_W'(red_n_q);
            green_cnt_q <= mcp_pkg::CNT_W'(green_n_q);
            blue_cnt_q  <= mcp_pkg::CNT_W'(blue_n_q);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign pix_i.ready       = (state_q == S_IDLE);
  assign res_o.valid       = out_valid_q;
  assign res_o.pixel_color = color_q;
  assign res_o.red_count   = red_cnt_q;
  assign res_o.green_count = green_cnt_q;
  assign res_o.blue_count  = blue_cnt_q;

endmodule

// ===== src/mcp_mul.sv =====
// shared signed 32x32 multiplier with registered full product
// depends on mcp_pkg
module mcp_mul (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [mcp_pkg::DATA_W-1:0] a_i,
  input  logic signed [mcp_pkg::DATA_W-1:0] b_i,
  output logic signed [2*mcp_pkg::DATA_W-1:0] p_o
);

  logic signed [2*mcp_pkg::DATA_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// ===== src/mcp_colour.sv =====
// iteration counts to rgb565 via the brightness table and channel scaling
// depends on mcp_pkg
module mcp_colour (
  input  logic [mcp_pkg::ITER_W-1:0]  red_n_i,
  input  logic [mcp_pkg::ITER_W-1:0]  green_n_i,
  input  logic [mcp_pkg::ITER_W-1:0]  blue_n_i,
  output logic [mcp_pkg::COLOR_W-1:0] color_o
);

  logic [7:0] r_br, g_br, b_br;
  logic [7:0] r_sc, g_sc, b_sc;

  function automatic logic [7:0] bright(input logic [mcp_pkg::ITER_W-1:0] n);
    logic [7:0] v;
    if (n >= mcp_pkg::ITER_W'(mcp_pkg::MAX_ITER)) begin
      v = 8'd0;
    end else begin
      v = mcp_pkg::BRIGHT_LUT[n[mcp_pkg::IDX_W-1:0]];
    end
    return v;
  endfunction

  assign r_br = bright(red_n_i);
  assign g_br = bright(green_n_i);
  assign b_br = bright(blue_n_i);

  assign r_sc = {r_br[6:0], 1'b0} + r_br;
  assign g_sc = {g_br[6:0], 1'b0};
  assign b_sc = {b_br[5:0], 2'b00};

  assign color_o = {r_sc[7:3], g_sc[7:2], b_sc[7:3]};

endmodule

// ===== src/mcp_chk.sv =====
// port-level checks for the chromatic mandelbrot core, bound to the top level
// depends on mcp_pkg and mandelbrot_chromatic_pixel_core
module mcp_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [mcp_pkg::COLOR_W-1:0]    pixel_color_i,
  input logic [mcp_pkg::CNT_W-1:0]      red_count_i,
  input logic [mcp_pkg::CNT_W-1:0]      green_count_i,
  input logic [mcp_pkg::CNT_W-1:0]      blue_count_i
);

  localparam logic [mcp_pkg::CNT_W-1:0] CNT_MAX = mcp_pkg::CNT_W'(mcp_pkg::MAX_ITER);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a pending result word stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped before it was taken");

  // busy after taking a pixel
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("pixel taken while still busy");

  // no result can appear straight after a pixel is taken
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_i))
    else $error("result word appeared too early");

  // points that never escape give dark channels
  a_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      ((red_count_i != CNT_MAX) || (pixel_color_i[15:11] == 5'd0)) &&
      ((green_count_i != CNT_MAX) || (pixel_color_i[10:5] == 6'd0)) &&
      ((blue_count_i != CNT_MAX) || (pixel_color_i[4:0] == 5'd0)))
    else $error("non-escaping channel is not dark");

endmodule

bind mandelbrot_chromatic_pixel_core mcp_chk u_mcp_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (pix_i.valid),
  .in_ready_i    (pix_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .pixel_color_i (res_o.pixel_color),
  .red_count_i   (res_o.red_count),
  .green_count_i (res_o.green_count),
  .blue_count_i  (res_o.blue_count)
);
